>>> sv/fis_pkg.sv
// Shared constants and helpers for the fringe isolation statistics block.
// Used by fis_divider and by the fringe_isolation_stats top level.
package fis_pkg;

	localparam int MAX_COUNT = 65536;
	localparam int FRAC_BITS = 16;

	localparam int SAMPLE_W = 32;
	localparam int ACC_W = 32;
	localparam int CNT_W = $clog2(MAX_COUNT + 1);
	// Ratio width: one integer bit above the fraction, so that 1.0 fits.
	localparam int Q_W = FRAC_BITS + 1;
	localparam int PROD_W = 2 * Q_W;
	localparam int SUM_W = ((Q_W > ACC_W) ? Q_W : ACC_W) + 1;
	localparam int DIV_CNT_W = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;

	localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;
	localparam logic [Q_W-1:0] Q_QUARTER = Q_ONE >> 2;
	localparam logic [CNT_W-1:0] MAX_CNT_V = CNT_W'(MAX_COUNT);

	// Saturating add of a ratio-width term to a 32-bit accumulator.
	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
			input logic [Q_W-1:0] b);
		logic [SUM_W-1:0] s;
		s = SUM_W'(a) + SUM_W'(b);
		if (s[SUM_W-1:ACC_W] != '0)
			return '1;
		return s[ACC_W-1:0];
	endfunction

endpackage

>>> sv/fis_divider.sv
// Radix-2 restoring divider: quotient = (diff << FRAC_BITS) / span for diff < span.
// One quotient bit per cycle. Depends on fis_pkg.
module fis_divider import fis_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SAMPLE_W-1:0] diff,
	input  logic [SAMPLE_W-1:0] span,
	output logic                done,
	output logic [FRAC_BITS-1:0] quotient
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic [SAMPLE_W-1:0]  rem_q;
	logic [SAMPLE_W-1:0]  span_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic                 done_q;

	logic [SAMPLE_W:0] rem2;
	logic              fits;
	logic [SAMPLE_W:0] rem_sub;

	assign rem2 = {rem_q, 1'b0};
	assign fits = rem2 >= {1'b0, span_q};
	assign rem_sub = rem2 - {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == DIV_CNT_W'(FRAC_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= diff;
			span_q <= span;
			quo_q <= '0;
		end else if (busy_q) begin
			// The remainder stays below span, so the doubled value fits in 33 bits.
			rem_q <= fits ? rem_sub[SAMPLE_W-1:0] : rem2[SAMPLE_W-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

>>> sv/fringe_isolation_stats.sv
// Top level of the fringe isolation statistics block. Depends on fis_pkg and fis_divider.
// Each word passes IDLE, PREP and FIN; the first two words of a run go from PREP straight to FIN,
// a zero-span word adds CMP and ACC, a ratio of 1 adds CMP, MUL and ACC, and a division adds
// CMP, DIV (the serial divider), MUL and ACC. One word is in work at a time, and the next is
// taken only back in IDLE; a marked word waits while an older result is stalled.
// Reset (asynchronous, active low) clears the run state and drops out_valid.
module fringe_isolation_stats import fis_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                is_last,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [ACC_W-1:0]    mean_value,
	output logic [ACC_W-1:0]    variance_value,
	output logic                count_overflow
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_CMP  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_ACC  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0] state_q;

	logic [SAMPLE_W-1:0] z_q;
	logic                last_q;
	logic [SAMPLE_W-1:0] first_q;
	logic [SAMPLE_W-1:0] prev_q;
	logic [CNT_W-1:0]    count_q;
	logic [ACC_W-1:0]    mean_q;
	logic [ACC_W-1:0]    var_q;
	logic                ovf_q;

	logic [SAMPLE_W-1:0] span_q;
	logic [SAMPLE_W-1:0] diff_q;
	logic                zspan_q;
	logic [Q_W-1:0]      r_q;
	logic [Q_W-1:0]      vadd_q;

	logic                out_valid_q;
	logic [ACC_W-1:0]    mean_out_q;
	logic [ACC_W-1:0]    var_out_q;
	logic                ovf_out_q;

	logic                 div_start;
	logic                 div_done;
	logic [FRAC_BITS-1:0] div_quo;
	logic [PROD_W-1:0]    prod;
	logic                 accept;
	logic                 out_free;
	logic                 emit;

	fis_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.diff     (diff_q),
		.span     (span_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign accept = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign div_start = (state_q == ST_CMP) && !zspan_q && (diff_q < span_q);
	assign prod = PROD_W'(r_q) * PROD_W'(Q_ONE - r_q);
	assign out_free = !out_valid_q || !out_stall;
	assign emit = (state_q == ST_FIN) && last_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			first_q <= '0;
			prev_q <= '0;
			count_q <= '0;
			mean_q <= '0;
			var_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					if (count_q == '0)
						first_q <= z_q;
					prev_q <= z_q;
					if (count_q >= MAX_CNT_V)
						ovf_q <= 1'b1;
					else
						count_q <= count_q + 1'b1;
					// The first two words of a run only set up the span.
					state_q <= (count_q < CNT_W'(2)) ? ST_FIN : ST_CMP;
				end
				ST_CMP: begin
					if (zspan_q)
						state_q <= ST_ACC;
					else if (diff_q >= span_q)
						state_q <= ST_MUL;
					else
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					mean_q <= sat_add(mean_q, r_q);
					var_q <= sat_add(var_q, vadd_q);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						first_q <= '0;
						prev_q <= '0;
						count_q <= '0;
						mean_q <= '0;
						var_q <= '0;
						ovf_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			z_q <= sample;
			last_q <= is_last;
		end
		if (state_q == ST_PREP) begin
			span_q <= z_q - first_q;
			diff_q <= (z_q > prev_q) ? (z_q - prev_q) : '0;
			zspan_q <= (z_q <= first_q);
		end
		if (state_q == ST_CMP) begin
			// A zero span adds one to the mean and a quarter to the variance.
			r_q <= Q_ONE;
			vadd_q <= Q_QUARTER;
		end
		if (div_done)
			r_q <= {1'b0, div_quo};
		if (state_q == ST_MUL)
			vadd_q <= prod[FRAC_BITS +: Q_W];
		if (emit) begin
			mean_out_q <= (count_q > CNT_W'(1)) ? sat_add(mean_q, Q_ONE) : '0;
			var_out_q <= (count_q > CNT_W'(1)) ? var_q : '0;
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign mean_value = mean_out_q;
	assign variance_value = var_out_q;
	assign count_overflow = ovf_out_q;

endmodule
